FILE: hw/rtl/plcs_pkg.sv
// shared types and constants for the piecewise linear contrast stretch
package plcs_pkg;

    localparam int PIX_W = 8;
    localparam int QUO_W = 9;
    localparam int REM_W = 18;
    localparam int DIV_STAGES = QUO_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BREAK_IN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BREAK_OUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BREAK_IN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BREAK_OUT = 2'd3;

    localparam logic [PIX_W-1:0] RST_LOW_BREAK_IN   = 8'd64;
    localparam logic [PIX_W-1:0] RST_LOW_BREAK_OUT  = 8'd64;
    localparam logic [PIX_W-1:0] RST_HIGH_BREAK_IN  = 8'd192;
    localparam logic [PIX_W-1:0] RST_HIGH_BREAK_OUT = 8'd192;

    typedef struct packed {
        logic [PIX_W-1:0] low_in;
        logic [PIX_W-1:0] low_out;
        logic [PIX_W-1:0] high_in;
        logic [PIX_W-1:0] high_out;
    } t_curve;

    typedef struct packed {
        logic             valid;
        logic             force_max;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] div_sh;
        logic [QUO_W-1:0] quo;
    } t_div_bus;

endpackage

FILE: hw/rtl/piecewise_linear_contrast_stretch.sv
// top level of the piecewise linear contrast stretch
// maps 8-bit grey pixels through a three-segment transfer curve
// input: a pixel is taken on each edge where i_start is high and o_busy is low;
//   o_busy is always low, so one pixel can enter every clock
// output: o_valid is high for one cycle with o_pixel_out once the pixel has passed
//   the pipeline, results in input order; the receiver cannot stall
// throughput: one pixel per clock, latency set by the 2 front stages,
//   the 9 single-bit divider stages and the output register
// configuration: i_cfg_valid/o_cfg_ready write channel, index 0 low break in,
//   1 low break out, 2 high break in, 3 high break out; o_cfg_ready always high;
//   write only while no pixel is in flight
// reset: synchronous active low, flushes the pipeline and restores the
//   breakpoints (64,64) and (192,192)
module piecewise_linear_contrast_stretch
    import plcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_valid,
    output logic [PIX_W-1:0]     o_pixel_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data
);

    localparam int LATENCY = 3 + DIV_STAGES;

    t_curve           r_curve;
    t_div_bus         div_bus [DIV_STAGES+1];
    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic             accept;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve.low_in   <= RST_LOW_BREAK_IN;
            r_curve.low_out  <= RST_LOW_BREAK_OUT;
            r_curve.high_in  <= RST_HIGH_BREAK_IN;
            r_curve.high_out <= RST_HIGH_BREAK_OUT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LOW_BREAK_IN:   r_curve.low_in   <= i_cfg_data;
                CFG_LOW_BREAK_OUT:  r_curve.low_out  <= i_cfg_data;
                CFG_HIGH_BREAK_IN:  r_curve.high_in  <= i_cfg_data;
                CFG_HIGH_BREAK_OUT: r_curve.high_out <= i_cfg_data;
                default: ;
            endcase
        end
    end

    plcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pixel (i_pixel_in),
        .i_curve (r_curve),
        .o_bus   (div_bus[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        plcs_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (div_bus[g]),
            .o_bus   (div_bus[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_bus[DIV_STAGES].valid;
        end
        // saturation safeguard
        if (div_bus[DIV_STAGES].force_max || div_bus[DIV_STAGES].quo[QUO_W-1]) begin
            r_pixel <= PIX_MAX;
        end else begin
            r_pixel <= div_bus[DIV_STAGES].quo[PIX_W-1:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_pixel_out = r_pixel;

    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("request did not produce a result");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, LATENCY)) |-> $past(accept, LATENCY))
        else $error("result without a request");

    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_pixel_in == PIX_MAX) |-> ##LATENCY (o_pixel_out == PIX_MAX))
        else $error("full-scale pixel not mapped to full scale");

endmodule

FILE: hw/rtl/plcs_front.sv
// segment selection and numerator build, two register stages
module plcs_front
    import plcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_curve           i_curve,
    output t_div_bus         o_bus
);

    logic             r_valid;
    logic             r_force;
    logic [PIX_W-1:0] r_a, r_b, r_c, r_d, r_den;
    logic [PIX_W-1:0] n_a, n_b, n_c, n_d, n_den;
    logic             n_force;

    logic [2*PIX_W-1:0] prod_ab;
    logic [2*PIX_W-1:0] prod_cd;
    logic [2*PIX_W:0]   num;
    logic [REM_W-1:0]   dividend;
    t_div_bus           r_bus;

    always_comb begin
        n_force = 1'b0;
        n_a     = '0;
        n_b     = '0;
        n_c     = '0;
        n_d     = '0;
        n_den   = 8'd1;
        priority if (i_pixel < i_curve.low_in) begin
            n_a   = i_curve.low_out;
            n_b   = i_pixel;
            n_den = i_curve.low_in;
        end else if (i_pixel < i_curve.high_in) begin
            n_a   = i_curve.low_out;
            n_b   = i_curve.high_in - i_pixel;
            n_c   = i_curve.high_out;
            n_d   = i_pixel - i_curve.low_in;
            n_den = i_curve.high_in - i_curve.low_in;
        end else if (i_pixel != PIX_MAX) begin
            n_a   = i_curve.high_out;
            n_b   = PIX_MAX - i_pixel;
            n_c   = PIX_MAX;
            n_d   = i_pixel - i_curve.high_in;
            n_den = PIX_MAX - i_curve.high_in;
        end else begin
            n_force = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_force <= n_force;
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_den   <= n_den;
    end

    // full-width products
    assign prod_ab  = {{PIX_W{1'b0}}, r_a} * {{PIX_W{1'b0}}, r_b};
    assign prod_cd  = {{PIX_W{1'b0}}, r_c} * {{PIX_W{1'b0}}, r_d};

    // half-up rounding: (2n + d) / 2d
    assign num      = {1'b0, prod_ab} + {1'b0, prod_cd};
    assign dividend = {num, 1'b0} + {{(REM_W-PIX_W){1'b0}}, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= r_valid;
        end
        r_bus.force_max <= r_force;
        r_bus.rem       <= dividend;
        r_bus.div_sh    <= {1'b0, r_den, {QUO_W{1'b0}}};
        r_bus.quo       <= '0;
    end

    assign o_bus = r_bus;

endmodule

FILE: hw/rtl/plcs_div_stage.sv
// one restoring division step, one quotient bit per stage
module plcs_div_stage
    import plcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_bus i_bus,
    output t_div_bus o_bus
);

    logic     ge;
    t_div_bus r_bus;

    assign ge = (i_bus.rem >= i_bus.div_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= i_bus.valid;
        end
        r_bus.force_max <= i_bus.force_max;
        r_bus.rem       <= ge ? i_bus.rem - i_bus.div_sh : i_bus.rem;
        r_bus.div_sh    <= {1'b0, i_bus.div_sh[REM_W-1:1]};
        r_bus.quo       <= {i_bus.quo[QUO_W-2:0], ge};
    end

    assign o_bus = r_bus;

endmodule
